>>> design/ctb_pkg.sv
// ----------------------------------------------------------------------------
// ctb_pkg: shared types and constants for the countdown timer bank
// Field widths, result codes, reset values and controller/datapath structs.
// ----------------------------------------------------------------------------
package ctb_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 16;
  localparam int unsigned MAX_RESULTS   = 16;

  localparam int unsigned TPS_W   = 10;
  localparam int unsigned SECS_W  = 16;
  localparam int unsigned TAG_W   = 8;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned NRES_W  = $clog2(MAX_RESULTS + 1);

  localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(50);

  typedef enum logic [1:0] {
    EV_TICK    = 2'd0,
    EV_EXPIRED = 2'd1,
    EV_ADD_OK  = 2'd2,
    EV_ADD_REJ = 2'd3
  } event_e;

  // controller -> datapath
  typedef struct packed {
    logic load;         // latch request; on a tick, advance tick counter / prescaler
    logic walk_step;    // process current slot of a second boundary, advance
    logic scan_next;    // add scan: move to next slot
    logic add_place;    // add scan: take current (free) slot
    logic emit_reject;  // add scan: no free slot
    logic emit_tick;    // tick with no expiry
    logic emit_final;   // flush held expiry as the last result
  } ctb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic boundary;     // the offered tick ends a second
    logic cur_active;   // slot under the index is in use
    logic walk_ok;      // current slot can be processed this cycle
    logic idx_last;     // index is on the last slot
    logic pend_valid;   // an expiry result is held back
    logic out_free;     // output register can take a result
  } ctb_status_t;

endpackage

>>> design/ctb_ram.sv
// ----------------------------------------------------------------------------
// ctb_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ctb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/ctb_ctrl.sv
// ----------------------------------------------------------------------------
// ctb_ctrl: sequencing state machine of the countdown timer bank
// Accepts one request at a time and steps the datapath through it.
// ----------------------------------------------------------------------------
module ctb_ctrl
  import ctb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        kind_i,
  output logic        in_stall_o,
  input  ctb_status_t st_i,
  output ctb_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PRIME  = 5'b00010,
    S_WALK   = 5'b00100,
    S_ADD    = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (kind_i) begin
            state_d = S_ADD;
          end else if (st_i.boundary) begin
            state_d = S_PRIME;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_PRIME: begin
        // slot 0 read is in flight
        state_d = S_WALK;
      end
      S_WALK: begin
        if (st_i.walk_ok) begin
          cmd_o.walk_step = 1'b1;
          if (st_i.idx_last) begin
            state_d = S_FINISH;
          end
        end
      end
      S_ADD: begin
        if (!st_i.cur_active) begin
          if (st_i.out_free) begin
            cmd_o.add_place = 1'b1;
            state_d         = S_IDLE;
          end
        end else if (st_i.idx_last) begin
          if (st_i.out_free) begin
            cmd_o.emit_reject = 1'b1;
            state_d           = S_IDLE;
          end
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      S_FINISH: begin
        if (st_i.out_free) begin
          if (st_i.pend_valid) begin
            cmd_o.emit_final = 1'b1;
          end else begin
            cmd_o.emit_tick = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // new work only enters from idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == S_IDLE)
    else $error("ctb_ctrl: load outside idle");

  // a boundary walk always starts from the read-priming state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PRIME |=> state_q == S_WALK)
    else $error("ctb_ctrl: prime not followed by walk");

  // at most one result is produced per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.add_place, cmd_o.emit_reject, cmd_o.emit_tick, cmd_o.emit_final}))
    else $error("ctb_ctrl: several result commands at once");

endmodule

>>> design/ctb_dp.sv
// ----------------------------------------------------------------------------
// ctb_dp: datapath of the countdown timer bank
// Tick counter, prescaler, slot store, held expiry and output register.
// ----------------------------------------------------------------------------
module ctb_dp
  import ctb_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF,
  localparam int unsigned IW       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [TPS_W-1:0]   cfg_wdata_i,
  input  logic               kind_i,
  input  logic [SECS_W-1:0]  seconds_i,
  input  logic [TAG_W-1:0]   tag_i,
  input  ctb_cmd_t           cmd_i,
  output ctb_status_t        st_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         event_res_o,
  output logic [SLOT_W-1:0]  slot_o,
  output logic [TAG_W-1:0]   tag_out_o,
  output logic [COUNT_W-1:0] tick_count_o,
  output logic               last_o
);

  localparam int unsigned RAM_W = SECS_W + TAG_W;

  logic [TPS_W-1:0]   tps_q;
  logic [TPS_W-1:0]   pres_q, pres_inc;
  logic [COUNT_W-1:0] tick_q;
  logic [NUM_SLOTS-1:0] active_q;
  logic [IW-1:0]      idx_q;
  logic [NRES_W-1:0]  nres_q;
  logic [SECS_W-1:0]  req_secs_q;
  logic [TAG_W-1:0]   req_tag_q;

  logic               pend_valid_q;
  logic [SLOT_W-1:0]  pend_slot_q;
  logic [TAG_W-1:0]   pend_tag_q;

  logic               out_valid_q;
  event_e             out_ev_q;
  logic [SLOT_W-1:0]  out_slot_q;
  logic [TAG_W-1:0]   out_tag_q;
  logic [COUNT_W-1:0] out_count_q;
  logic               out_last_q;

  logic [RAM_W-1:0]   ram_rdata, ram_wdata;
  logic [IW-1:0]      ram_raddr;
  logic               ram_we;
  logic [SECS_W-1:0]  cur_secs, dec_secs;
  logic [TAG_W-1:0]   cur_tag;
  logic               cur_active, cur_due, cur_expire, out_free, emit;

  // ---- prescaler ----
  assign pres_inc    = pres_q + TPS_W'(1);
  assign st_o.boundary = (pres_inc >= tps_q);

  // ---- slot store ----
  assign cur_secs   = ram_rdata[RAM_W-1:TAG_W];
  assign cur_tag    = ram_rdata[TAG_W-1:0];
  assign cur_active = active_q[idx_q];
  assign cur_due    = (cur_secs <= SECS_W'(1));
  assign cur_expire = cur_active && cur_due && (nres_q < NRES_W'(MAX_RESULTS));
  assign dec_secs   = cur_due ? '0 : (cur_secs - SECS_W'(1));

  // keep reading the current slot until it is processed
  assign ram_raddr = cmd_i.walk_step ? (idx_q + IW'(1)) : idx_q;
  assign ram_we    = cmd_i.add_place || (cmd_i.walk_step && cur_active && !cur_expire);
  assign ram_wdata = cmd_i.add_place ? {req_secs_q, req_tag_q} : {dec_secs, cur_tag};

  ctb_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---- status ----
  assign out_free        = !out_valid_q || !out_stall_i;
  assign st_o.cur_active = cur_active;
  assign st_o.walk_ok    = !(cur_expire && pend_valid_q && !out_free);
  assign st_o.idx_last   = (idx_q == IW'(NUM_SLOTS - 1));
  assign st_o.pend_valid = pend_valid_q;
  assign st_o.out_free   = out_free;

  assign emit = cmd_i.add_place || cmd_i.emit_reject || cmd_i.emit_tick ||
                cmd_i.emit_final || (cmd_i.walk_step && cur_expire && pend_valid_q);

  // ---- control state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q        <= TPS_RESET;
      pres_q       <= '0;
      tick_q       <= '0;
      active_q     <= '0;
      idx_q        <= '0;
      nres_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tps_q <= cfg_wdata_i;
      end
      out_valid_q <= emit || (out_valid_q && out_stall_i);
      if (cmd_i.load) begin
        idx_q        <= '0;
        nres_q       <= '0;
        pend_valid_q <= 1'b0;
        if (!kind_i) begin
          tick_q <= tick_q + COUNT_W'(1);
          pres_q <= st_o.boundary ? '0 : pres_inc;
        end
      end
      if (cmd_i.walk_step || cmd_i.scan_next) begin
        idx_q <= idx_q + IW'(1);
      end
      if (cmd_i.walk_step && cur_expire) begin
        active_q[idx_q] <= 1'b0;
        pend_valid_q    <= 1'b1;
        nres_q          <= nres_q + NRES_W'(1);
      end
      if (cmd_i.add_place) begin
        active_q[idx_q] <= 1'b1;
      end
      if (cmd_i.emit_final) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_secs_q <= seconds_i;
      req_tag_q  <= tag_i;
    end
    if (cmd_i.walk_step && cur_expire) begin
      pend_slot_q <= SLOT_W'(idx_q);
      pend_tag_q  <= cur_tag;
    end
    // tick count travels with its result; a later tick may load meanwhile
    if (emit) begin
      out_count_q <= tick_q;
    end
    if (cmd_i.walk_step && cur_expire && pend_valid_q) begin
      out_ev_q   <= EV_EXPIRED;
      out_slot_q <= pend_slot_q;
      out_tag_q  <= pend_tag_q;
      out_last_q <= 1'b0;
    end else if (cmd_i.emit_final) begin
      out_ev_q   <= EV_EXPIRED;
      out_slot_q <= pend_slot_q;
      out_tag_q  <= pend_tag_q;
      out_last_q <= 1'b1;
    end else if (cmd_i.add_place) begin
      out_ev_q   <= EV_ADD_OK;
      out_slot_q <= SLOT_W'(idx_q);
      out_tag_q  <= req_tag_q;
      out_last_q <= 1'b1;
    end else if (cmd_i.emit_reject) begin
      out_ev_q   <= EV_ADD_REJ;
      out_slot_q <= '0;
      out_tag_q  <= req_tag_q;
      out_last_q <= 1'b1;
    end else if (cmd_i.emit_tick) begin
      out_ev_q   <= EV_TICK;
      out_slot_q <= '0;
      out_tag_q  <= '0;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_res_o  = out_ev_q;
  assign slot_o       = out_slot_q;
  assign tag_out_o    = out_tag_q;
  assign tick_count_o = out_count_q;
  assign last_o       = out_last_q;

  // an add never lands on a busy slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.add_place |-> !active_q[idx_q])
    else $error("ctb_dp: add on active slot");

  // no result overwrites one the receiver has not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("ctb_dp: output register overrun");

  // expiry count per boundary stays within the result limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    nres_q <= NRES_W'(MAX_RESULTS))
    else $error("ctb_dp: expiry count overflow");

  // the final flush always has a held expiry behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_final |-> pend_valid_q)
    else $error("ctb_dp: final flush without held expiry");

endmodule

>>> design/countdown_timer_bank.sv
// ----------------------------------------------------------------------------
// countdown_timer_bank: bank of one-shot countdown timers
// Tick requests drive a prescaled seconds countdown; add requests arm slots.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (in_valid_i / in_stall_o): kind_i = 0 is a tick,
//    kind_i = 1 arms a timer with seconds_i and tag_i in the lowest free slot.
//  - Result channel (out_valid_o / out_stall_i): one result per request, or
//    one per expired slot on a second boundary; last_o flags the final one.
//  - cfg_we_i / cfg_wdata_i set ticks per second (reset 50); write it while
//    the bank is idle.
//  - Requests are handled one at a time. A tick that does not end a second
//    passes through the finish state, where its result is registered. A tick
//    that ends a second walks the slot store once, one slot per cycle through
//    its single read port while no result stall holds the walk. An add scans
//    the in-use bits one slot per cycle.
//  - One expiry is held back until the next is found or the walk ends, so
//    last_o can be set on the real final result.
//  - Reset clears the tick counter, the prescaler and all in-use bits; the
//    slot store itself is not cleared, since only in-use slot data is used.
//  - A stalled receiver holds the result register; the walk pauses only when
//    a further result has nowhere to go.
// ----------------------------------------------------------------------------
module countdown_timer_bank
  import ctb_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [TPS_W-1:0]   cfg_wdata_i,
  // requests
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [SECS_W-1:0]  seconds_i,
  input  logic [TAG_W-1:0]   tag_i,
  // results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         event_res_o,
  output logic [SLOT_W-1:0]  slot_o,
  output logic [TAG_W-1:0]   tag_out_o,
  output logic [COUNT_W-1:0] tick_count_o,
  output logic               last_o
);

  ctb_cmd_t    cmd;
  ctb_status_t st;

  // sequencer: owns the request handshake
  ctb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // datapath: counters, slot store and result register
  ctb_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .kind_i       (kind_i),
    .seconds_i    (seconds_i),
    .tag_i        (tag_i),
    .cmd_i        (cmd),
    .st_o         (st),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_res_o  (event_res_o),
    .slot_o       (slot_o),
    .tag_out_o    (tag_out_o),
    .tick_count_o (tick_count_o),
    .last_o       (last_o)
  );

endmodule
